// ----- hdl/chd_pkg.sv -----
// ============================================================================
// chd_pkg
// Shared types and constants of the canonical Huffman decoder.
// ============================================================================
package chd_pkg;

   localparam int unsigned MaxSymbolsDefault  = 288;
   localparam int unsigned MaxCodeBitsDefault = 15;
   localparam int unsigned LenWidth           = 4;
   localparam int unsigned SymWidth           = 9;
   localparam int unsigned StatusWidth        = 3;
   localparam int unsigned WindowWidth        = 15;
   localparam int unsigned NumLengths         = 16;

   typedef enum logic [1:0] {
      CMD_LOAD   = 2'd0,
      CMD_BUILD  = 2'd1,
      CMD_DECODE = 2'd2,
      CMD_CLEAR  = 2'd3
   } command_type;

   typedef enum logic [StatusWidth-1:0] {
      ST_OK         = 3'd0,
      ST_INCOMPLETE = 3'd1,
      ST_BAD_TREE   = 3'd2,
      ST_INVALID    = 3'd3,
      ST_FULL       = 3'd4
   } status_type;

   typedef enum logic [3:0] {
      S_IDLE,
      S_CNT_RD,
      S_CNT_WAIT,
      S_CHECK,
      S_ASSIGN,
      S_PLACE_RD,
      S_PLACE_WAIT,
      S_PLACE_WR,
      S_DEC_SCAN,
      S_DEC_RD,
      S_DEC_OUT,
      S_DONE
   } state_type;

endpackage

// ----- hdl/canonical_huffman_decoder_core.sv -----
// ============================================================================
// canonical_huffman_decoder_core
// Canonical Huffman decoder for DEFLATE code length sets.
// ============================================================================
// A request is taken when start is high and busy is low. command selects:
// load a code length (stored at the next symbol index), build the table,
// decode the stream window, or clear. Each request gives exactly one result,
// shown for one cycle with rsp_valid; the receiver cannot stall it.
// Decode tries one code length per cycle, then on a hit reads the symbol
// memory before the result. Build makes two passes over the length memory,
// one for counting and one for placing, with a check and an assignment
// step per code length between them.
// busy is high from acceptance through the result cycle. The configuration
// write port (csr_valid, csr_ready) holds max_code_length; ready is high
// while idle. Reset empties the table, zeroes the load count and sets
// max_code_length to 15. The length and symbol memories need no clearing.
// ============================================================================
module canonical_huffman_decoder_core
   import chd_pkg::*;
#(
   parameter int unsigned MAX_SYMBOLS   = MaxSymbolsDefault,
   parameter int unsigned MAX_CODE_BITS = MaxCodeBitsDefault
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   start,
   output logic                   busy,
   input  logic [1:0]             req_command,
   input  logic [LenWidth-1:0]    req_code_length,
   input  logic [WindowWidth-1:0] req_stream_bits,
   input  logic [LenWidth-1:0]    req_bits_available,
   output logic                   rsp_valid,
   output logic [StatusWidth-1:0] rsp_status,
   output logic [SymWidth-1:0]    rsp_decoded_symbol,
   output logic [LenWidth-1:0]    rsp_bits_consumed,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [LenWidth-1:0]    csr_max_code_length
);

   localparam int unsigned AW = $clog2(MAX_SYMBOLS);
   localparam int unsigned CW = $clog2(MAX_SYMBOLS + 1);
   localparam logic [CW-1:0] FullCount = CW'(MAX_SYMBOLS);
   localparam logic [LenWidth-1:0] CodeBitsLimit =
      (MAX_CODE_BITS > 15) ? 4'd15 : LenWidth'(MAX_CODE_BITS);

   logic [LenWidth-1:0] len_mem [MAX_SYMBOLS];
   logic [SymWidth-1:0] sym_mem [MAX_SYMBOLS];
   logic [LenWidth-1:0] len_rd_ff;
   logic [SymWidth-1:0] sym_rd_ff;

   state_type state_ff, state_in;
   logic [LenWidth-1:0] maxlen_ff;
   logic [CW-1:0] loaded_ff, loaded_in;
   logic [CW-1:0] idx_ff, idx_in;
   logic [CW-1:0] cnt_ff [NumLengths];
   logic [16:0] first_code_ff [NumLengths];
   logic [CW-1:0] first_idx_ff [NumLengths];
   logic [CW-1:0] slot_ff [NumLengths];
   logic [LenWidth-1:0] longest_ff;
   logic valid_ff;
   logic [4:0] len_ff, len_in;
   logic [17:0] left_ff;
   logic [15:0] code_ff;
   logic [CW-1:0] acc_ff;
   logic [15:0] dcode_ff;
   logic [LenWidth-1:0] dlen_ff;
   logic [CW-1:0] pos_ff;
   logic [WindowWidth-1:0] win_ff;
   logic [LenWidth-1:0] avail_ff;
   logic bad_ff;
   logic [StatusWidth-1:0] st_ff;

   logic [LenWidth-1:0] limit;
   logic [LenWidth-1:0] cur_len;
   logic [15:0] dcode_next;
   logic [16:0] doff;
   logic dhit;
   logic oversub;

   assign limit = (maxlen_ff > CodeBitsLimit) ? CodeBitsLimit : maxlen_ff;
   assign cur_len = len_ff[LenWidth-1:0];
   assign dcode_next = {dcode_ff[14:0], win_ff[cur_len - 4'd1]};
   assign doff = {1'b0, dcode_next} - first_code_ff[cur_len];
   assign dhit = ({1'b0, dcode_next} >= first_code_ff[cur_len]) &&
                 (doff < 17'(cnt_ff[cur_len]));
   assign oversub = !bad_ff && (18'(slot_ff[cur_len]) > {left_ff[16:0], 1'b0});

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      len_in = len_ff;
      loaded_in = loaded_ff;
      case (state_ff)
         S_IDLE: begin
            if (start) begin
               idx_in = '0;
               len_in = 5'd1;
               case (command_type'(req_command))
                  CMD_BUILD: state_in = S_CNT_RD;
                  CMD_DECODE: state_in = S_DEC_SCAN;
                  default: state_in = S_DONE;
               endcase
            end
         end
         S_CNT_RD: state_in = (idx_ff == loaded_ff) ? S_CHECK : S_CNT_WAIT;
         S_CNT_WAIT: begin
            idx_in = idx_ff + 1'b1;
            state_in = S_CNT_RD;
         end
         S_CHECK: begin
            if (bad_ff || oversub) begin
               state_in = S_DONE;
            end else if (len_ff == 5'd15) begin
               len_in = 5'd1;
               state_in = S_ASSIGN;
            end else begin
               len_in = len_ff + 1'b1;
            end
         end
         S_ASSIGN: begin
            if (len_ff == 5'd15) begin
               idx_in = '0;
               state_in = S_PLACE_RD;
            end else begin
               len_in = len_ff + 1'b1;
            end
         end
         S_PLACE_RD: state_in = (idx_ff == loaded_ff) ? S_DONE : S_PLACE_WAIT;
         S_PLACE_WAIT: state_in = S_PLACE_WR;
         S_PLACE_WR: begin
            idx_in = idx_ff + 1'b1;
            state_in = S_PLACE_RD;
         end
         S_DEC_SCAN: begin
            if (!valid_ff || avail_ff == '0 || dhit ||
                len_ff >= {1'b0, longest_ff}) begin
               state_in = (valid_ff && avail_ff != '0 && dhit) ? S_DEC_RD : S_DONE;
            end else begin
               len_in = len_ff + 1'b1;
            end
         end
         S_DEC_RD: state_in = S_DEC_OUT;
         S_DEC_OUT: state_in = S_IDLE;
         S_DONE: state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
      if (state_ff == S_IDLE && start) begin
         if (command_type'(req_command) == CMD_LOAD && loaded_ff != FullCount) begin
            loaded_in = loaded_ff + 1'b1;
         end else if (command_type'(req_command) == CMD_CLEAR) begin
            loaded_in = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == S_IDLE && start &&
          command_type'(req_command) == CMD_LOAD && loaded_ff != FullCount) begin
         len_mem[loaded_ff[AW-1:0]] <= req_code_length;
      end
      len_rd_ff <= len_mem[idx_ff[AW-1:0]];
      if (state_ff == S_PLACE_WR && len_rd_ff != '0 &&
          slot_ff[len_rd_ff] < FullCount) begin
         sym_mem[slot_ff[len_rd_ff][AW-1:0]] <= SymWidth'(idx_ff);
      end
      sym_rd_ff <= sym_mem[pos_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         maxlen_ff <= 4'd15;
         loaded_ff <= '0;
         longest_ff <= '0;
         valid_ff <= 1'b0;
         for (int k = 0; k < NumLengths; k++) begin
            cnt_ff[k] <= '0;
            first_code_ff[k] <= '0;
            first_idx_ff[k] <= '0;
            slot_ff[k] <= '0;
         end
      end else begin
         state_ff <= state_in;
         loaded_ff <= loaded_in;
         if (csr_valid && csr_ready) begin
            maxlen_ff <= csr_max_code_length;
         end
         if (state_ff == S_IDLE && start) begin
            if (command_type'(req_command) == CMD_BUILD) begin
               for (int k = 0; k < NumLengths; k++) begin
                  slot_ff[k] <= '0;
               end
               longest_ff <= '0;
            end
            if (command_type'(req_command) == CMD_CLEAR) begin
               valid_ff <= 1'b0;
               longest_ff <= '0;
            end
         end
         if (state_ff == S_CNT_WAIT && len_rd_ff != '0 && !bad_ff) begin
            slot_ff[len_rd_ff] <= slot_ff[len_rd_ff] + 1'b1;
            if (len_rd_ff > longest_ff) begin
               longest_ff <= len_rd_ff;
            end
         end
         if (state_ff == S_CHECK && (bad_ff || oversub)) begin
            valid_ff <= 1'b0;
            longest_ff <= '0;
         end
         if (state_ff == S_ASSIGN) begin
            cnt_ff[cur_len] <= slot_ff[cur_len];
            first_code_ff[cur_len] <= {1'b0, code_ff};
            first_idx_ff[cur_len] <= acc_ff;
            slot_ff[cur_len] <= acc_ff;
         end
         if (state_ff == S_PLACE_WR && len_rd_ff != '0) begin
            slot_ff[len_rd_ff] <= slot_ff[len_rd_ff] + 1'b1;
         end
         if (state_ff == S_PLACE_RD && idx_ff == loaded_ff) begin
            valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      idx_ff <= idx_in;
      len_ff <= len_in;
      case (state_ff)
         S_IDLE: begin
            win_ff <= req_stream_bits & WindowWidth'((16'd1 << req_bits_available) - 16'd1);
            avail_ff <= req_bits_available;
            bad_ff <= 1'b0;
            left_ff <= 18'd1;
            code_ff <= '0;
            acc_ff <= '0;
            dcode_ff <= '0;
            st_ff <= ST_OK;
            if (start) begin
               case (command_type'(req_command))
                  CMD_LOAD: st_ff <= (loaded_ff == FullCount) ? ST_FULL : ST_OK;
                  CMD_DECODE: st_ff <= ST_INVALID;
                  default: st_ff <= ST_OK;
               endcase
            end
         end
         S_CNT_WAIT: begin
            if (len_rd_ff > limit) begin
               bad_ff <= 1'b1;
               st_ff <= ST_BAD_TREE;
            end
         end
         S_CHECK: begin
            if (oversub) begin
               bad_ff <= 1'b1;
               st_ff <= ST_BAD_TREE;
            end else if (!bad_ff) begin
               left_ff <= {left_ff[16:0], 1'b0} - 18'(slot_ff[cur_len]);
            end
         end
         S_ASSIGN: begin
            code_ff <= {(code_ff[14:0] + 15'(slot_ff[cur_len])), 1'b0};
            acc_ff <= acc_ff + slot_ff[cur_len];
         end
         S_DEC_SCAN: begin
            dcode_ff <= dcode_next;
            pos_ff <= first_idx_ff[cur_len] + CW'(doff);
            dlen_ff <= cur_len;
            if (!valid_ff) begin
               st_ff <= ST_INVALID;
            end else if (avail_ff == '0) begin
               st_ff <= ST_INCOMPLETE;
            end else if (dhit) begin
               st_ff <= ({1'b0, cur_len} > {1'b0, avail_ff}) ? ST_INCOMPLETE : ST_OK;
            end else begin
               st_ff <= ST_INVALID;
            end
         end
         default: ;
      endcase
   end

   logic out_ok;
   assign out_ok = (state_ff == S_DEC_OUT) && (st_ff == ST_OK);

   always_comb begin
      busy = (state_ff != S_IDLE);
      csr_ready = (state_ff == S_IDLE);
      rsp_valid = (state_ff == S_DONE) || (state_ff == S_DEC_OUT);
      rsp_status = st_ff;
      rsp_decoded_symbol = out_ok ? ((pos_ff < FullCount) ? sym_rd_ff : '0) : '0;
      rsp_bits_consumed = out_ok ? dlen_ff : '0;
   end

endmodule

// ----- hdl/chd_checker.sv -----
// ============================================================================
// chd_checker
// Port-level checks of the canonical Huffman decoder.
// ============================================================================
module chd_checker
   import chd_pkg::*;
(
   input logic                   clock,
   input logic                   reset,
   input logic                   start,
   input logic                   busy,
   input logic                   rsp_valid,
   input logic [StatusWidth-1:0] rsp_status,
   input logic [SymWidth-1:0]    rsp_decoded_symbol,
   input logic [LenWidth-1:0]    rsp_bits_consumed,
   input logic                   csr_ready
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy)
      else $error("Accepted request did not raise busy.");

   a_result_ends: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !busy)
      else $error("Busy held after result.");

   a_result_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> busy)
      else $error("Result shown while idle.");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ST_OK |->
         rsp_decoded_symbol == '0 && rsp_bits_consumed == '0)
      else $error("Non-zero payload on failed request.");

   a_csr_idle: assert property (@(posedge clock) disable iff (reset)
      csr_ready |-> !busy)
      else $error("Configuration ready while busy.");

endmodule

bind canonical_huffman_decoder_core chd_checker u_chd_checker (
   .clock(clock),
   .reset(reset),
   .start(start),
   .busy(busy),
   .rsp_valid(rsp_valid),
   .rsp_status(rsp_status),
   .rsp_decoded_symbol(rsp_decoded_symbol),
   .rsp_bits_consumed(rsp_bits_consumed),
   .csr_ready(csr_ready)
);

// ----- bench/canonical_huffman_decoder_core_test.sv -----
`timescale 1ns / 100ps
// ============================================================================
// canonical_huffman_decoder_core_test
// Self-checking bench for the canonical Huffman decoder core.
// ============================================================================
// A short table of directed requests covers the corner cases. Random code
// length sets follow, most of them well formed, and each set is built and
// then decoded with random windows. The max_code_length register is changed
// between phases while the core is idle. Each result is held to the
// typed answer of its directed row or to a bench model of the code table.
// ============================================================================
module canonical_huffman_decoder_core_test;
   import chd_pkg::*;

   localparam int NumSymbols   = 288;
   localparam int TargetItems  = 1150;
   localparam int CycleLimit   = 2000000;

   typedef struct packed {
      status_type  st;
      logic [8:0]  sym;
      logic [3:0]  used;
   } answer_type;

   typedef struct {
      command_type cmd;
      logic [3:0]  len;
      logic [14:0] bits;
      logic [3:0]  avail;
      bit          typed;
      answer_type  ans;
   } stim_row_type;

   logic clock, reset, start, busy, rsp_valid, csr_valid, csr_ready;
   logic [1:0] req_command;
   logic [3:0] req_code_length, req_bits_available, rsp_bits_consumed;
   logic [3:0] csr_max_code_length;
   logic [14:0] req_stream_bits;
   logic [2:0] rsp_status;
   logic [8:0] rsp_decoded_symbol;

   canonical_huffman_decoder_core u_top (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_command(req_command), .req_code_length(req_code_length),
      .req_stream_bits(req_stream_bits), .req_bits_available(req_bits_available),
      .rsp_valid(rsp_valid), .rsp_status(rsp_status),
      .rsp_decoded_symbol(rsp_decoded_symbol), .rsp_bits_consumed(rsp_bits_consumed),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_max_code_length(csr_max_code_length)
   );

   // Bench copy of the decoder state.
   logic [3:0] lengths_m[NumSymbols];
   int         loaded_m;
   int         cnt_m[16], first_code_m[16], first_idx_m[16];
   int         sorted_m[NumSymbols];
   int         longest_m;
   bit         table_ok_m;
   int         max_len_m;

   answer_type pending_answers[$];
   bit         mismatch_seen;
   int         items_sent;
   int         cycles;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   function automatic void drop_table();
      for (int l = 0; l < 16; l++) begin
         cnt_m[l] = 0; first_code_m[l] = 0; first_idx_m[l] = 0;
      end
      longest_m  = 0;
      table_ok_m = 1'b0;
   endfunction

   function automatic status_type build_code_table();
      int counts[16];
      int slot[16];
      int left, code, idx, longest, l;
      left = 1; code = 0; idx = 0; longest = 0;
      for (int k = 0; k < 16; k++) counts[k] = 0;
      for (int i = 0; i < loaded_m; i++) begin
         l = int'(lengths_m[i]);
         if (l != 0) begin
            if (l > max_len_m) begin
               drop_table();
               return ST_BAD_TREE;
            end
            counts[l]++;
            if (l > longest) longest = l;
         end
      end
      for (int k = 1; k < 16; k++) begin
         left = left << 1;
         if (counts[k] > left) begin
            drop_table();
            return ST_BAD_TREE;
         end
         left -= counts[k];
      end
      drop_table();
      for (int k = 1; k < 16; k++) begin
         code = (code + counts[k-1]) << 1;
         cnt_m[k] = counts[k];
         first_code_m[k] = code & 16'hFFFF;
         first_idx_m[k] = idx;
         slot[k] = idx;
         idx += counts[k];
      end
      for (int i = 0; i < loaded_m; i++) begin
         l = int'(lengths_m[i]);
         if (l != 0) begin
            if (slot[l] < NumSymbols) sorted_m[slot[l]] = i;
            slot[l]++;
         end
      end
      longest_m  = longest;
      table_ok_m = 1'b1;
      return ST_OK;
   endfunction

   function automatic answer_type decode_window(logic [14:0] bits, int avail);
      answer_type a;
      int code, off, pos, win;
      a = '{ST_INVALID, 9'd0, 4'd0};
      if (!table_ok_m) return a;
      if (avail == 0) begin
         a.st = ST_INCOMPLETE;
         return a;
      end
      win = int'(bits) & ((1 << avail) - 1);
      code = 0;
      for (int l = 1; l <= longest_m; l++) begin
         code = (code << 1) | ((win >> (l - 1)) & 1);
         if (code >= first_code_m[l]) begin
            off = code - first_code_m[l];
            if (off < cnt_m[l]) begin
               if (l > avail) begin
                  a.st = ST_INCOMPLETE;
                  return a;
               end
               pos = first_idx_m[l] + off;
               a.st = ST_OK;
               a.sym = 9'((pos < NumSymbols) ? sorted_m[pos] : 0);
               a.used = 4'(l);
               return a;
            end
         end
      end
      return a;
   endfunction

   function automatic answer_type apply_request(command_type cmd, logic [3:0] len,
                                                logic [14:0] bits, logic [3:0] avail);
      answer_type a;
      a = '{ST_OK, 9'd0, 4'd0};
      case (cmd)
         CMD_LOAD: begin
            if (loaded_m < NumSymbols) begin
               lengths_m[loaded_m] = len;
               loaded_m++;
            end else begin
               a.st = ST_FULL;
            end
         end
         CMD_BUILD:  a.st = build_code_table();
         CMD_DECODE: a = decode_window(bits, int'(avail));
         default: begin
            drop_table();
            loaded_m = 0;
         end
      endcase
      return a;
   endfunction

   function automatic int pick_gap();
      int r;
      r = $urandom_range(99);
      if (r < 65) return 0;
      if (r < 95) return $urandom_range(3, 1);
      return $urandom_range(40, 10);
   endfunction

   task automatic send(command_type cmd, logic [3:0] len, logic [14:0] bits,
                       logic [3:0] avail, bit typed, answer_type typed_ans);
      answer_type a;
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         start = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_command = cmd;
      req_code_length = len;
      req_stream_bits = bits;
      req_bits_available = avail;
      start = 1'b1;
      @(posedge clock);
      while (busy) @(posedge clock);
      a = apply_request(cmd, len, bits, avail);
      pending_answers.push_back(typed ? typed_ans : a);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_rand(command_type cmd, logic [3:0] len, logic [14:0] bits,
                            logic [3:0] avail);
      send(cmd, len, bits, avail, 1'b0, '{ST_OK, 9'd0, 4'd0});
   endtask

   task automatic write_max_length(logic [3:0] value);
      start = 1'b0;
      wait (pending_answers.size() == 0);
      repeat (3) @(negedge clock);
      csr_max_code_length = value;
      csr_valid = 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      max_len_m = value;
      @(negedge clock);
      csr_valid = 1'b0;
   endtask

   // Random window, mostly a full one.
   task automatic send_decode();
      logic [3:0] avail;
      avail = ($urandom_range(9) < 7) ? 4'd15 : 4'($urandom_range(15));
      send_rand(CMD_DECODE, 4'($urandom), 15'($urandom), avail);
   endtask

   // Loads a random code length set, builds it and decodes from it.
   task automatic run_code_set(int max_len);
      int lens[$];
      int n, idx, tries, tmp, j;
      lens = '{1, 1};
      n = ($urandom_range(19) == 0) ? $urandom_range(286, 40) : $urandom_range(30, 2);
      tries = 0;
      while (lens.size() < n && tries < 4000) begin
         idx = $urandom_range(lens.size() - 1);
         if (lens[idx] < max_len) begin
            lens[idx]++;
            lens.insert(idx, lens[idx]);
         end
         tries++;
      end
      if ($urandom_range(3) == 0 && lens.size() > 1) lens.delete($urandom_range(lens.size() - 1));
      if ($urandom_range(7) == 0) lens.push_back($urandom_range(15, 1));
      tmp = $urandom_range(4);
      for (int k = 0; k < tmp && lens.size() < 288; k++) lens.push_back(0);
      for (int k = lens.size() - 1; k > 0; k--) begin
         j = $urandom_range(k);
         tmp = lens[k]; lens[k] = lens[j]; lens[j] = tmp;
      end
      if ($urandom_range(7) != 0) send_rand(CMD_CLEAR, 4'($urandom), 15'($urandom), 4'($urandom));
      foreach (lens[k]) send_rand(CMD_LOAD, 4'(lens[k]), 15'($urandom), 4'($urandom));
      send_rand(CMD_BUILD, 4'($urandom), 15'($urandom), 4'($urandom));
      n = $urandom_range(40, 10);
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(19) == 0)
            send_rand(CMD_LOAD, 4'($urandom), 15'($urandom), 4'($urandom));
         else
            send_decode();
      end
   endtask

   always @(posedge clock) begin
      answer_type want;
      if (!reset && rsp_valid) begin
         if (pending_answers.size() == 0) begin
            $error("result with nothing expected: status %0d", rsp_status);
            mismatch_seen = 1'b1;
         end else begin
            want = pending_answers.pop_front();
            if (rsp_status !== want.st) begin
               $error("status: expected %0d, got %0d", want.st, rsp_status);
               mismatch_seen = 1'b1;
            end
            if (rsp_decoded_symbol !== want.sym) begin
               $error("decoded_symbol: expected %0d, got %0d", want.sym, rsp_decoded_symbol);
               mismatch_seen = 1'b1;
            end
            if (rsp_bits_consumed !== want.used) begin
               $error("bits_consumed: expected %0d, got %0d", want.used, rsp_bits_consumed);
               mismatch_seen = 1'b1;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CycleLimit) begin
         $display("SCOREBOARD MISMATCH");
         $finish;
      end
   end

   stim_row_type dir_rows[24];

   initial begin
      int seq_num, waited;
      cycles = 0;
      mismatch_seen = 1'b0;
      items_sent = 0;
      reset = 1'b1;
      start = 1'b0;
      req_command = CMD_LOAD;
      req_code_length = '0;
      req_stream_bits = '0;
      req_bits_available = '0;
      csr_valid = 1'b0;
      csr_max_code_length = 4'd15;
      loaded_m = 0;
      max_len_m = 15;
      drop_table();

      dir_rows = '{
         '{CMD_DECODE, 4'd0, 15'h7FFF, 4'd15, 1'b1, '{ST_INVALID, 9'd0, 4'd0}},
         '{CMD_BUILD, 4'd0, 15'h0, 4'd0, 1'b1, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_DECODE, 4'd0, 15'h7FFF, 4'd0, 1'b1, '{ST_INCOMPLETE, 9'd0, 4'd0}},
         '{CMD_DECODE, 4'd0, 15'h7FFF, 4'd15, 1'b1, '{ST_INVALID, 9'd0, 4'd0}},
         '{CMD_LOAD, 4'd2, 15'h7FFF, 4'd15, 1'b1, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_LOAD, 4'd1, 15'h0, 4'd0, 1'b1, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_LOAD, 4'd3, 15'h0, 4'd0, 1'b1, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_LOAD, 4'd3, 15'h0, 4'd0, 1'b1, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_BUILD, 4'd0, 15'h0, 4'd0, 1'b1, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_DECODE, 4'd0, 15'h0, 4'd1, 1'b0, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_DECODE, 4'd0, 15'h1, 4'd15, 1'b0, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_DECODE, 4'd0, 15'h3, 4'd15, 1'b0, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_DECODE, 4'd0, 15'h7FFF, 4'd15, 1'b0, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_DECODE, 4'd0, 15'h7, 4'd2, 1'b1, '{ST_INCOMPLETE, 9'd0, 4'd0}},
         '{CMD_LOAD, 4'd15, 15'h0, 4'd0, 1'b1, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_DECODE, 4'd0, 15'h0, 4'd15, 1'b0, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_BUILD, 4'd0, 15'h0, 4'd0, 1'b1, '{ST_BAD_TREE, 9'd0, 4'd0}},
         '{CMD_DECODE, 4'd0, 15'h0, 4'd15, 1'b1, '{ST_INVALID, 9'd0, 4'd0}},
         '{CMD_CLEAR, 4'd15, 15'h7FFF, 4'd15, 1'b1, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_LOAD, 4'd1, 15'h0, 4'd0, 1'b1, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_LOAD, 4'd1, 15'h0, 4'd0, 1'b1, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_LOAD, 4'd1, 15'h0, 4'd0, 1'b1, '{ST_OK, 9'd0, 4'd0}},
         '{CMD_BUILD, 4'd0, 15'h0, 4'd0, 1'b1, '{ST_BAD_TREE, 9'd0, 4'd0}},
         '{CMD_CLEAR, 4'd0, 15'h0, 4'd0, 1'b1, '{ST_OK, 9'd0, 4'd0}}
      };

      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      foreach (dir_rows[r])
         send(dir_rows[r].cmd, dir_rows[r].len, dir_rows[r].bits, dir_rows[r].avail,
              dir_rows[r].typed, dir_rows[r].ans);

      // A length above the register limit is rejected.
      write_max_length(4'd2);
      send_rand(CMD_LOAD, 4'd2, 15'h0, 4'd0);
      send_rand(CMD_LOAD, 4'd1, 15'h0, 4'd0);
      send_rand(CMD_LOAD, 4'd3, 15'h0, 4'd0);
      send_rand(CMD_BUILD, 4'd0, 15'h0, 4'd0);
      send_decode();
      write_max_length(4'd15);

      seq_num = 0;
      while (items_sent < TargetItems) begin
         if (seq_num % 8 == 7) begin
            case ($urandom_range(3))
               0: write_max_length(4'd1);
               1: write_max_length(4'd15);
               default: write_max_length(4'($urandom_range(15, 1)));
            endcase
         end
         if ($urandom_range(29) == 0) begin
            send_rand(CMD_CLEAR, 4'($urandom), 15'($urandom), 4'($urandom));
            repeat (NumSymbols + 2) send_rand(CMD_LOAD, 4'($urandom), 15'($urandom), 4'($urandom));
            send_rand(CMD_BUILD, 4'($urandom), 15'($urandom), 4'($urandom));
            repeat (5) send_decode();
         end else if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(12, 3))
               send_rand(command_type'($urandom_range(3)), 4'($urandom), 15'($urandom),
                         4'($urandom));
         end else begin
            run_code_set((max_len_m < 1) ? 1 : max_len_m);
         end
         seq_num++;
      end

      start = 1'b0;
      waited = 0;
      while (pending_answers.size() != 0 && waited < 100000) begin
         @(posedge clock);
         waited++;
      end
      repeat (30) @(posedge clock);
      if (!mismatch_seen && pending_answers.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         if (pending_answers.size() != 0)
            $error("%0d results never arrived", pending_answers.size());
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

// ----- files.f -----
hdl/chd_pkg.sv
hdl/canonical_huffman_decoder_core.sv
hdl/chd_checker.sv
bench/canonical_huffman_decoder_core_test.sv
